FILE: design/icmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmn_pkg: shared types and constants
// Item formats, configuration layout, register map and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package icmn_pkg;

   localparam int MAX_DIM_DEF      = 512;
   localparam int MAX_CHANNELS_DEF = 3;

   localparam int PIXEL_W   = 8;
   localparam int OFS_W     = 9;
   localparam int DIM_REG_W = 10;
   localparam int CH_REG_W  = 2;
   localparam int SCALE_W   = 24;
   localparam int MEAN_W    = 16;
   localparam int MEANS_W   = 48;
   localparam int DEST_W    = 20;
   localparam int VALUE_W   = 32;
   localparam int FRAC_SHIFT = 8;

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_LSB     = 3;

   localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST  = 10'd224;
   localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST   = 10'd224;
   localparam logic [CH_REG_W-1:0]  CHANNEL_COUNT_RST = 2'd3;
   localparam logic [DIM_REG_W-1:0] CROP_SIZE_RST     = 10'd0;
   localparam logic [SCALE_W-1:0]   SCALE_RST         = 24'd65536;
   localparam logic [MEANS_W-1:0]   MEANS_RST         = 48'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_HEIGHT  = 3'd0,
      REG_IMAGE_WIDTH   = 3'd1,
      REG_CHANNEL_COUNT = 3'd2,
      REG_CROP_SIZE     = 3'd3,
      REG_RANDOM_CROP   = 3'd4,
      REG_MIRROR_ENABLE = 3'd5,
      REG_SCALE         = 3'd6,
      REG_CHANNEL_MEANS = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               first_of_image;
      logic [OFS_W-1:0]   row_offset;
      logic [OFS_W-1:0]   col_offset;
      logic               mirror_request;
   } req_type;

   typedef struct packed {
      logic [DEST_W-1:0]         dest_index;
      logic signed [VALUE_W-1:0] value;
      logic                      last_of_image;
   } rsp_type;

   typedef struct packed {
      logic [DIM_REG_W-1:0] image_height;
      logic [DIM_REG_W-1:0] image_width;
      logic [CH_REG_W-1:0]  channel_count;
      logic [DIM_REG_W-1:0] crop_size;
      logic                 random_crop;
      logic                 mirror_enable;
      logic [SCALE_W-1:0]   scale;
      logic [MEANS_W-1:0]   channel_means;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic fin;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: design/icmn_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmn_regs: configuration registers
// Register file behind the bus port, one 64-bit slot per register.
// ----------------------------------------------------------------------------
module icmn_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [icmn_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [icmn_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [icmn_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output icmn_pkg::cfg_type                      cfg
);

   icmn_pkg::cfg_type     cfg_ff;
   icmn_pkg::csr_reg_type index;
   logic                  wr_en;

   assign index = icmn_pkg::csr_reg_type'(
      csr_paddr[icmn_pkg::CSR_LSB +: icmn_pkg::CSR_INDEX_W]);
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height  <= icmn_pkg::IMAGE_HEIGHT_RST;
         cfg_ff.image_width   <= icmn_pkg::IMAGE_WIDTH_RST;
         cfg_ff.channel_count <= icmn_pkg::CHANNEL_COUNT_RST;
         cfg_ff.crop_size     <= icmn_pkg::CROP_SIZE_RST;
         cfg_ff.random_crop   <= 1'b0;
         cfg_ff.mirror_enable <= 1'b0;
         cfg_ff.scale         <= icmn_pkg::SCALE_RST;
         cfg_ff.channel_means <= icmn_pkg::MEANS_RST;
      end else if (wr_en) begin
         case (index)
            icmn_pkg::REG_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_pwdata[icmn_pkg::DIM_REG_W-1:0];
            end
            icmn_pkg::REG_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_pwdata[icmn_pkg::DIM_REG_W-1:0];
            end
            icmn_pkg::REG_CHANNEL_COUNT: begin
               cfg_ff.channel_count <= csr_pwdata[icmn_pkg::CH_REG_W-1:0];
            end
            icmn_pkg::REG_CROP_SIZE: begin
               cfg_ff.crop_size <= csr_pwdata[icmn_pkg::DIM_REG_W-1:0];
            end
            icmn_pkg::REG_RANDOM_CROP: begin
               cfg_ff.random_crop <= csr_pwdata[0];
            end
            icmn_pkg::REG_MIRROR_ENABLE: begin
               cfg_ff.mirror_enable <= csr_pwdata[0];
            end
            icmn_pkg::REG_SCALE: begin
               cfg_ff.scale <= csr_pwdata[icmn_pkg::SCALE_W-1:0];
            end
            icmn_pkg::REG_CHANNEL_MEANS: begin
               cfg_ff.channel_means <= csr_pwdata[icmn_pkg::MEANS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         icmn_pkg::REG_IMAGE_HEIGHT:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.image_height);
         icmn_pkg::REG_IMAGE_WIDTH:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.image_width);
         icmn_pkg::REG_CHANNEL_COUNT:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.channel_count);
         icmn_pkg::REG_CROP_SIZE:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.crop_size);
         icmn_pkg::REG_RANDOM_CROP:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.random_crop);
         icmn_pkg::REG_MIRROR_ENABLE:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.mirror_enable);
         icmn_pkg::REG_SCALE:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.scale);
         icmn_pkg::REG_CHANNEL_MEANS:
            csr_prdata = icmn_pkg::CSR_DATA_W'(cfg_ff.channel_means);
         default:
            csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: design/icmn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmn_ctrl: item sequencer
// Steps one item through accept, two multiply stages and the hand-off to
// the output register.
// ----------------------------------------------------------------------------
module icmn_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire icmn_pkg::sts_type sts,
   output icmn_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_FIN,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   assign req_stall = stall_ff;

   always_comb begin
      cmd.load = req_valid && !stall_ff;
      cmd.mul  = (state_ff == S_MUL);
      cmd.fin  = (state_ff == S_FIN);
      cmd.push = (state_ff == S_PUSH) && (!sts.keep || sts.out_free);
      case (state_ff)
         S_IDLE:  state_in = cmd.load ? S_MUL : S_IDLE;
         S_MUL:   state_in = S_FIN;
         S_FIN:   state_in = S_PUSH;
         S_PUSH:  state_in = cmd.push ? S_IDLE : S_PUSH;
         default: state_in = S_IDLE;
      endcase
      stall_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

`ifndef SYNTHESIS
   a_load_then_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.mul)
      else $error("accepted item did not enter the multiply stage");

   a_mul_then_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.fin)
      else $error("multiply stage not followed by final stage");
`endif

endmodule
`default_nettype wire

FILE: design/icmn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icmn_dp: crop, mirror and normalize datapath
// Position counters, crop window test, index and value multipliers and the
// output register.
// ----------------------------------------------------------------------------
module icmn_dp #(
   parameter int MAX_DIM      = icmn_pkg::MAX_DIM_DEF,
   parameter int MAX_CHANNELS = icmn_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire icmn_pkg::cfg_type cfg,
   input  wire icmn_pkg::req_type req_data,
   input  wire icmn_pkg::cmd_type cmd,
   output icmn_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output icmn_pkg::rsp_type      rsp_data
);

   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int CW  = $clog2(MAX_DIM);
   localparam int NCW = $clog2(MAX_CHANNELS + 1);
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int XW  = (DW > icmn_pkg::DIM_REG_W) ? DW : icmn_pkg::DIM_REG_W;
   localparam int OW  = (DW > icmn_pkg::OFS_W) ? DW : icmn_pkg::OFS_W;
   localparam int NXW = (NCW > icmn_pkg::CH_REG_W) ? NCW : icmn_pkg::CH_REG_W;
   localparam int LW  = DW + CHW + 1;
   localparam int LW2 = LW + DW + 1;
   localparam int DIFF_W = icmn_pkg::PIXEL_W + icmn_pkg::FRAC_SHIFT + 1;
   localparam int PROD_W = DIFF_W + icmn_pkg::SCALE_W + 1;
   localparam int VW = icmn_pkg::VALUE_W;
   localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(1) << (icmn_pkg::FRAC_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI =
      {{(PROD_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_LO =
      {{(PROD_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

   function automatic logic [DW-1:0] clamp_dim(input logic [icmn_pkg::DIM_REG_W-1:0] v);
      logic [XW-1:0] vx;
      vx = XW'(v);
      if (v == '0) return DW'(1);
      if (vx > XW'(MAX_DIM)) return DW'(MAX_DIM);
      return DW'(vx);
   endfunction

   function automatic logic [DW-1:0] crop_side(input logic [DW-1:0] dim,
                                               input logic [icmn_pkg::DIM_REG_W-1:0] crop);
      logic [XW-1:0] cx;
      cx = XW'(crop);
      if (crop == '0) return dim;
      if (cx > XW'(dim)) return dim;
      return DW'(cx);
   endfunction

   function automatic logic [CW-1:0] pick_offset(input logic [DW-1:0] dim,
                                                 input logic [DW-1:0] side,
                                                 input logic [icmn_pkg::OFS_W-1:0] req,
                                                 input logic no_crop,
                                                 input logic random);
      logic [DW-1:0] room;
      room = dim - side;
      if (no_crop) return '0;
      if (random) return (OW'(req) > OW'(room)) ? CW'(room) : CW'(req);
      return CW'(room >> 1);
   endfunction

   // position and latched window
   logic [CW-1:0]  row_ff, col_ff, row_in, col_in;
   logic [CHW-1:0] chan_ff, chan_in;
   logic [CW-1:0]  top_ff, left_ff;
   logic           mirror_ff;

   // stage registers
   logic                     s_keep_ff, s_last_ff;
   logic [CHW-1:0]           s_chan_ff;
   logic [CW-1:0]            s_r_ff, s_x_ff;
   logic signed [DIFF_W-1:0] s_diff_ff;
   logic [LW-1:0]            lin_ff, lin_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [icmn_pkg::DEST_W-1:0] dest_ff, dest_in;
   logic signed [VW-1:0]     val_ff, val_in;
   logic                     last_ff;
   icmn_pkg::rsp_type        rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [DW-1:0]  h, w, oh, ow;
   logic [NCW-1:0] nc, chan_inc;
   logic [NXW-1:0] ncx;
   logic [CW-1:0]  top_new, left_new, top_e, left_e;
   logic           mirror_e, first;
   logic [CW-1:0]  row_e, col_e, rr, cc, x;
   logic [CHW-1:0] chan_e;
   logic [DW-1:0]  row_inc, col_inc;
   logic           keep, last;
   logic [icmn_pkg::MEAN_W-1:0] mean;
   logic signed [DIFF_W-1:0]    diff;
   logic [LW2-1:0]              dest_full;
   logic signed [PROD_W-1:0]    rounded, shifted;

   always_comb begin
      first = req_data.first_of_image;
      h  = clamp_dim(cfg.image_height);
      w  = clamp_dim(cfg.image_width);
      ncx = NXW'(cfg.channel_count);
      if (cfg.channel_count == '0) nc = NCW'(1);
      else if (ncx > NXW'(MAX_CHANNELS)) nc = NCW'(MAX_CHANNELS);
      else nc = NCW'(ncx);
      oh = crop_side(h, cfg.crop_size);
      ow = crop_side(w, cfg.crop_size);
      top_new  = pick_offset(h, oh, req_data.row_offset, cfg.crop_size == '0,
                             cfg.random_crop);
      left_new = pick_offset(w, ow, req_data.col_offset, cfg.crop_size == '0,
                             cfg.random_crop);
      top_e    = first ? top_new : top_ff;
      left_e   = first ? left_new : left_ff;
      mirror_e = first ? (cfg.mirror_enable && req_data.mirror_request) : mirror_ff;

      row_e  = (first || DW'(row_ff) >= h) ? '0 : row_ff;
      col_e  = (first || DW'(col_ff) >= w) ? '0 : col_ff;
      chan_e = (first || NCW'(chan_ff) >= nc) ? '0 : chan_ff;

      rr = row_e - top_e;
      cc = col_e - left_e;
      keep = (row_e >= top_e) && (DW'(rr) < oh) && (col_e >= left_e) && (DW'(cc) < ow);
      x = mirror_e ? CW'(ow - DW'(1) - DW'(cc)) : cc;
      last = (DW'(rr) == oh - DW'(1)) && (DW'(cc) == ow - DW'(1)) &&
             (NCW'(chan_e) == nc - NCW'(1));

      case (2'(chan_e))
         2'd0:    mean = cfg.channel_means[0 +: icmn_pkg::MEAN_W];
         2'd1:    mean = cfg.channel_means[icmn_pkg::MEAN_W +: icmn_pkg::MEAN_W];
         2'd2:    mean = cfg.channel_means[2*icmn_pkg::MEAN_W +: icmn_pkg::MEAN_W];
         default: mean = '0;
      endcase
      diff = $signed({1'b0, req_data.pixel, {icmn_pkg::FRAC_SHIFT{1'b0}}}) -
             $signed({1'b0, mean});

      // advance position
      chan_inc = NCW'(chan_e) + NCW'(1);
      col_inc  = DW'(col_e) + DW'(1);
      row_inc  = DW'(row_e) + DW'(1);
      chan_in  = CHW'(chan_inc);
      col_in   = col_e;
      row_in   = row_e;
      if (chan_inc >= nc) begin
         chan_in = '0;
         if (col_inc >= w) begin
            col_in = '0;
            row_in = (row_inc >= h) ? '0 : CW'(row_inc);
         end else begin
            col_in = CW'(col_inc);
         end
      end

      lin_in  = LW'(s_chan_ff) * LW'(oh) + LW'(s_r_ff);
      prod_in = s_diff_ff * $signed({1'b0, cfg.scale});

      dest_full = LW2'(lin_ff) * LW2'(ow) + LW2'(s_x_ff);
      dest_in   = icmn_pkg::DEST_W'(dest_full);
      rounded   = prod_ff + ROUND;
      shifted   = rounded >>> icmn_pkg::FRAC_SHIFT;
      if (shifted > SAT_HI) val_in = SAT_HI[VW-1:0];
      else if (shifted < SAT_LO) val_in = SAT_LO[VW-1:0];
      else val_in = shifted[VW-1:0];

      if (cmd.push && s_keep_ff) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         chan_ff      <= '0;
         top_ff       <= '0;
         left_ff      <= '0;
         mirror_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            chan_ff <= chan_in;
            if (first) begin
               top_ff    <= top_new;
               left_ff   <= left_new;
               mirror_ff <= mirror_e;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_keep_ff <= keep;
         s_last_ff <= last;
         s_chan_ff <= chan_e;
         s_r_ff    <= rr;
         s_x_ff    <= x;
         s_diff_ff <= diff;
      end
      if (cmd.mul) begin
         lin_ff  <= lin_in;
         prod_ff <= prod_in;
      end
      if (cmd.fin) begin
         dest_ff <= dest_in;
         val_ff  <= val_in;
         last_ff <= s_last_ff;
      end
      if (cmd.push && s_keep_ff) begin
         rsp_ff.dest_index    <= dest_ff;
         rsp_ff.value         <= val_ff;
         rsp_ff.last_of_image <= last_ff;
      end
   end

   assign sts.keep     = s_keep_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && s_keep_ff) |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending item overwritten in output register");

   a_valid_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.push && s_keep_ff))
      else $error("output valid raised without a kept item");
`endif

endmodule
`default_nettype wire

FILE: design/image_crop_mirror_normalize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_crop_mirror_normalize: crop, mirror and normalize stream stage
// Keeps samples inside a crop window, subtracts the channel mean,
// scales, and emits each kept sample with its planar destination index.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    icmn_pkg::req_type
//   rsp      out        rsp_valid/stall    icmn_pkg::rsp_type
//   csr      in/out     psel/penable/rdy   64-bit registers at 8*index
//
// An item passes through accept, index and value multiply, final multiply and
// saturation, hand-off to the output register, one item at a time. Reset is
// synchronous, clears counters, crop origin, mirror flag and output valid, and
// sets register defaults; req_stall is high during reset and the cycle after.
// A stalled output holds its item while the next one is worked.
// ----------------------------------------------------------------------------
module image_crop_mirror_normalize #(
   parameter int MAX_DIM      = icmn_pkg::MAX_DIM_DEF,
   parameter int MAX_CHANNELS = icmn_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire icmn_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output icmn_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [icmn_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [icmn_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [icmn_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   icmn_pkg::cfg_type cfg;
   icmn_pkg::cmd_type cmd;
   icmn_pkg::sts_type sts;

   icmn_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   icmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   icmn_dp #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for image_crop_mirror_normalize
// Streams pixel samples through the crop, mirror and normalize stage under
// random sender gaps and receiver stalls. A scoreboard tracks the crop window,
// mirror flag and scan position, computes the planar index and the scaled,
// mean-subtracted value of every kept sample, and compares each result item
// in order. Registers change over the APB port only while the stage is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned DIM_LIMIT  = icmn_pkg::MAX_DIM_DEF;
   localparam int unsigned CHAN_LIMIT = icmn_pkg::MAX_CHANNELS_DEF;
   localparam int RANDOM_ITEMS  = 800;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PRINT_LIMIT   = 200;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_kind_type;

   class sample_scoreboard;
      icmn_pkg::cfg_type regs;
      int unsigned       row_pos, col_pos, chan_pos, top_row, left_col;
      bit                mirror_on;
      icmn_pkg::rsp_type pending[$];
      int                errors;

      function new();
         regs = '0;
         regs.image_height  = icmn_pkg::IMAGE_HEIGHT_RST;
         regs.image_width   = icmn_pkg::IMAGE_WIDTH_RST;
         regs.channel_count = icmn_pkg::CHANNEL_COUNT_RST;
         regs.crop_size     = icmn_pkg::CROP_SIZE_RST;
         regs.scale         = icmn_pkg::SCALE_RST;
         regs.channel_means = icmn_pkg::MEANS_RST;
      endfunction

      function void write_reg(icmn_pkg::csr_reg_type idx, logic [63:0] val);
         case (idx)
            icmn_pkg::REG_IMAGE_HEIGHT:
               regs.image_height  = val[icmn_pkg::DIM_REG_W-1:0];
            icmn_pkg::REG_IMAGE_WIDTH:
               regs.image_width   = val[icmn_pkg::DIM_REG_W-1:0];
            icmn_pkg::REG_CHANNEL_COUNT:
               regs.channel_count = val[icmn_pkg::CH_REG_W-1:0];
            icmn_pkg::REG_CROP_SIZE:
               regs.crop_size     = val[icmn_pkg::DIM_REG_W-1:0];
            icmn_pkg::REG_RANDOM_CROP:
               regs.random_crop   = val[0];
            icmn_pkg::REG_MIRROR_ENABLE:
               regs.mirror_enable = val[0];
            icmn_pkg::REG_SCALE:
               regs.scale         = val[icmn_pkg::SCALE_W-1:0];
            icmn_pkg::REG_CHANNEL_MEANS:
               regs.channel_means = val[icmn_pkg::MEANS_W-1:0];
            default: begin
            end
         endcase
      endfunction

      function int unsigned fit_dim(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function int unsigned window_side(int unsigned dim);
         if (regs.crop_size == 0) return dim;
         return (regs.crop_size > dim) ? dim : regs.crop_size;
      endfunction

      function int unsigned origin(int unsigned dim, int unsigned side, int unsigned req);
         int unsigned room;
         room = dim - side;
         if (regs.crop_size == 0) return 0;
         if (regs.random_crop) return (req > room) ? room : req;
         return room / 2;
      endfunction

      function void note_pixel(icmn_pkg::req_type it);
         int unsigned       h, w, nc, oh, ow, r, c, x;
         longint            diff, prod, q;
         icmn_pkg::rsp_type want;
         h  = fit_dim(regs.image_height, DIM_LIMIT);
         w  = fit_dim(regs.image_width, DIM_LIMIT);
         nc = fit_dim(regs.channel_count, CHAN_LIMIT);
         oh = window_side(h);
         ow = window_side(w);
         if (it.first_of_image) begin
            row_pos   = 0;
            col_pos   = 0;
            chan_pos  = 0;
            top_row   = origin(h, oh, it.row_offset);
            left_col  = origin(w, ow, it.col_offset);
            mirror_on = regs.mirror_enable & it.mirror_request;
         end
         if (row_pos >= h) row_pos = 0;
         if (col_pos >= w) col_pos = 0;
         if (chan_pos >= nc) chan_pos = 0;
         if (row_pos >= top_row && row_pos - top_row < oh &&
             col_pos >= left_col && col_pos - left_col < ow) begin
            r = row_pos - top_row;
            c = col_pos - left_col;
            x = mirror_on ? ow - 1 - c : c;
            diff = longint'(it.pixel) * 256 -
                   longint'(regs.channel_means[16*chan_pos +: icmn_pkg::MEAN_W]);
            prod = diff * longint'(regs.scale) + 128;
            q = prod >>> icmn_pkg::FRAC_SHIFT;
            if (q > VALUE_MAX) q = VALUE_MAX;
            if (q < VALUE_MIN) q = VALUE_MIN;
            want.dest_index    = icmn_pkg::DEST_W'((chan_pos * oh + r) * ow + x);
            want.value         = q[31:0];
            want.last_of_image = (r == oh - 1 && c == ow - 1 && chan_pos == nc - 1);
            pending = {pending, want};
         end
         chan_pos++;
         if (chan_pos >= nc) begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= h) row_pos = 0;
            end
         end
      endfunction

      task report(string what);
         if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(icmn_pkg::rsp_type got);
         icmn_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected item index %0d value %0d",
                             got.dest_index, got.value));
            return;
         end
         want = pending.pop_front();
         if (got.dest_index !== want.dest_index)
            report($sformatf("dest_index %0d, want %0d", got.dest_index, want.dest_index));
         if (got.value !== want.value)
            report($sformatf("value %0d, want %0d at index %0d",
                             got.value, want.value, want.dest_index));
         if (got.last_of_image !== want.last_of_image)
            report($sformatf("last_of_image %b, want %b at index %0d",
                             got.last_of_image, want.last_of_image, want.dest_index));
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   icmn_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   icmn_pkg::rsp_type               rsp_data;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [icmn_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [icmn_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [icmn_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   sample_scoreboard samples;
   stall_kind_type   stall_kind = STALL_NONE;
   int               stall_left = 0;
   int               idle_cycles = 0;
   int               burst_left = 0;
   int               items_sent = 0;

   image_crop_mirror_normalize dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) samples.check_result(rsp_data);
         if (req_valid && req_stall === 1'b0) samples.note_pixel(req_data);
         if (stall_left == 0) begin
            stall_kind = stall_kind_type'($urandom_range(0, 3));
            stall_left = (stall_kind == STALL_HOLD) ? $urandom_range(1, 12)
                                                    : $urandom_range(16, 128);
         end
         stall_left--;
         case (stall_kind)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("image_crop_mirror_normalize regression: fail");
         $finish;
      end
   end

   task automatic push_sample(icmn_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (samples.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(icmn_pkg::csr_reg_type idx, logic [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= icmn_pkg::CSR_ADDR_W'(idx) << icmn_pkg::CSR_LSB;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      samples.write_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_dim();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return 64'd1023;
         2:       return 64'd512;
         3:       return 64'($urandom_range(0, 1023));
         default: return 64'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic run_random_phase();
      int unsigned       eff_h, eff_w, eff_nc, per_image, count;
      logic [63:0]       val;
      icmn_pkg::req_type it;
      bit                first;
      wait_drained();
      set_reg(icmn_pkg::REG_IMAGE_HEIGHT, pick_dim());
      set_reg(icmn_pkg::REG_IMAGE_WIDTH, pick_dim());
      set_reg(icmn_pkg::REG_CHANNEL_COUNT, 64'($urandom_range(0, 3)));
      case ($urandom_range(0, 7))
         0:       val = 64'd0;
         1:       val = 64'd1023;
         2:       val = 64'd1;
         3:       val = 64'($urandom_range(0, 1023));
         default: val = 64'($urandom_range(1, 8));
      endcase
      set_reg(icmn_pkg::REG_CROP_SIZE, val);
      set_reg(icmn_pkg::REG_RANDOM_CROP, 64'($urandom_range(0, 1)));
      set_reg(icmn_pkg::REG_MIRROR_ENABLE, 64'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
         0:       val = 64'd0;
         1:       val = 64'hFF_FFFF;
         2:       val = 64'd65536;
         default: val = 64'($urandom_range(0, 24'hFF_FFFF));
      endcase
      set_reg(icmn_pkg::REG_SCALE, val);
      case ($urandom_range(0, 4))
         0:       val = 64'd0;
         1:       val = 64'hFFFF_FFFF_FFFF;
         default: val = {16'd0, 16'($urandom), 32'($urandom)};
      endcase
      set_reg(icmn_pkg::REG_CHANNEL_MEANS, val);

      eff_h  = samples.fit_dim(samples.regs.image_height, DIM_LIMIT);
      eff_w  = samples.fit_dim(samples.regs.image_width, DIM_LIMIT);
      eff_nc = samples.fit_dim(samples.regs.channel_count, CHAN_LIMIT);
      per_image = eff_h * eff_w * eff_nc;
      if (per_image > 240) per_image = $urandom_range(20, 80);
      repeat ($urandom_range(1, 3)) begin
         count = per_image;
         if ($urandom_range(0, 5) == 0) count += $urandom_range(1, 12);
         for (int k = 0; k < count && items_sent < RANDOM_ITEMS; k++) begin
            first = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0);
            it.pixel          = 8'($urandom);
            it.first_of_image = first;
            it.mirror_request = 1'($urandom);
            if (first && $urandom_range(0, 1)) begin
               it.row_offset = icmn_pkg::OFS_W'($urandom_range(0, eff_h));
               it.col_offset = icmn_pkg::OFS_W'($urandom_range(0, eff_w));
            end else begin
               it.row_offset = icmn_pkg::OFS_W'($urandom);
               it.col_offset = icmn_pkg::OFS_W'($urandom);
            end
            push_sample(it);
            items_sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      icmn_pkg::req_type it;
      samples = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, no first mark yet
      for (int k = 0; k < 6; k++) begin
         it.pixel          = (k % 2) ? 8'd255 : 8'(k * 50);
         it.first_of_image = 1'b0;
         it.row_offset     = '1;
         it.col_offset     = '1;
         it.mirror_request = 1'b1;
         push_sample(it);
      end
      req_valid <= 1'b0;

      // clamped random offsets, mirror, saturation both ways
      wait_drained();
      set_reg(icmn_pkg::REG_IMAGE_HEIGHT, 64'd2);
      set_reg(icmn_pkg::REG_IMAGE_WIDTH, 64'd3);
      set_reg(icmn_pkg::REG_CHANNEL_COUNT, 64'd3);
      set_reg(icmn_pkg::REG_CROP_SIZE, 64'd2);
      set_reg(icmn_pkg::REG_RANDOM_CROP, 64'd1);
      set_reg(icmn_pkg::REG_MIRROR_ENABLE, 64'd1);
      set_reg(icmn_pkg::REG_SCALE, 64'hFF_FFFF);
      set_reg(icmn_pkg::REG_CHANNEL_MEANS, {16'd0, 16'h8000, 16'h0000, 16'hFFFF});
      for (int k = 0; k < 18; k++) begin
         it.pixel          = (k % 2) ? 8'd0 : 8'd255;
         it.first_of_image = (k == 0);
         it.row_offset     = (k == 0) ? '1 : '0;
         it.col_offset     = (k == 0) ? '1 : '0;
         it.mirror_request = (k == 0);
         push_sample(it);
      end
      req_valid <= 1'b0;

      while (items_sent < RANDOM_ITEMS) run_random_phase();
      wait_drained();
      if (samples.errors == 0)
         $display("image_crop_mirror_normalize regression: pass");
      else
         $display("image_crop_mirror_normalize regression: fail");
      $finish;
   end
endmodule

FILE: filelist.f
design/icmn_pkg.sv
design/icmn_regs.sv
design/icmn_ctrl.sv
design/icmn_dp.sv
design/image_crop_mirror_normalize.sv
tb/tb.sv
